[sv/table_linear_interpolator_assert.svh]
// Assertion macros used by the checker file.
`ifndef TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define TLI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TLI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[sv/tli_pkg.sv]
// Package with types and constants of the interpolation table.
`default_nettype none
package tli_pkg;
   localparam int unsigned TableDepthDefault = 32;
   localparam int unsigned QueueDepth = 2;

   localparam logic [1:0] StatusInterp = 2'd0;
   localparam logic [1:0] StatusExact  = 2'd1;
   localparam logic [1:0] StatusRange  = 2'd2;
   localparam logic [1:0] StatusEmpty  = 2'd3;

   localparam logic OpWrite = 1'b0;
   localparam logic OpQuery = 1'b1;

   // One input word handed from the front to the back, writes and queries alike,
   // so that the back sees them in arrival order.
   typedef struct packed {
      logic               op;
      logic [4:0]         index;
      logic               wr_ok;
      logic signed [15:0] angle;
      logic signed [15:0] coefficient;
      logic [6:0]         count;
   } query_type;

   // One result word.
   typedef struct packed {
      logic signed [15:0] value;
      logic [1:0]         status;
      logic               saturated;
   } result_type;
endpackage
`default_nettype wire

[sv/tli_front.sv]
// Front end: takes input words, classifies them and queues them for the back end.
`default_nettype none
module tli_front import tli_pkg::*; #(
   parameter int unsigned TableDepth = TableDepthDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic               operation,
   input  wire logic [4:0]         point_index,
   input  wire logic signed [15:0] angle,
   input  wire logic signed [15:0] coefficient,
   input  wire logic [5:0]         points_used,
   output logic                    q_valid,
   output query_type               q_word,
   input  wire logic               q_take
);
   query_type   slot_ff [QueueDepth];
   logic [1:0]  cnt_ff, cnt_in;
   logic        rd_ff, wr_ff;
   logic        accept;
   logic        wr_ok;
   logic [6:0]  n_clip;

   assign full = (cnt_ff == 2'(QueueDepth));
   assign accept = push && !full;
   // A count above the table depth acts as the depth.
   assign n_clip = (32'(points_used) > TableDepth) ? 7'(TableDepth) : 7'(points_used);
   // Writes past the end of the table are dropped by the back end.
   assign wr_ok = ({27'd0, point_index} < 32'(TableDepth));

   assign q_valid = (cnt_ff != 2'd0);
   assign q_word = slot_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (accept && !(q_take && q_valid)) cnt_in = cnt_ff + 2'd1;
      if (!accept && q_take && q_valid) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) wr_ff <= ~wr_ff;
         if (q_take && q_valid) rd_ff <= ~rd_ff;
      end
      if (accept) begin
         slot_ff[wr_ff] <= '{op: operation, index: point_index, wr_ok: wr_ok,
            angle: angle, coefficient: coefficient, count: n_clip};
      end
   end
endmodule
`default_nettype wire

[sv/tli_back.sv]
// Back end: table memory, scan for the breakpoints, serial divider.
`default_nettype none
module tli_back import tli_pkg::*; #(
   parameter int unsigned TableDepth = TableDepthDefault,
   parameter int unsigned IndexBits = $clog2(TableDepth)
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_valid,
   input  wire query_type       q_word,
   output logic                 q_take,
   output logic                 rsp_valid,
   output result_type           rsp_word,
   input  wire logic            rsp_take
);
   typedef enum logic [3:0] {
      IDLE, RD_FIRST, RD_LAST, SCAN, WAIT_RD, GET_LO, MUL, DIV, ROUND, DONE
   } state_type;

   localparam int unsigned CntBits = IndexBits + 1;

   logic [31:0]          mem [TableDepth];
   logic [31:0]          rd_data_ff;
   logic [IndexBits-1:0] rd_addr;
   logic                 wr_en;
   logic [IndexBits-1:0] wr_index;
   logic [31:0]          wr_data;
   state_type            state_ff;
   logic signed [15:0]   q_ff, first_ff, a1_ff;
   logic signed [15:0]   c1_ff;
   logic [CntBits-1:0]   n_ff, i_ff;
   logic [IndexBits-1:0] hi_ff;
   logic                 found_ff, exact_ff, inrange_ff;
   logic signed [15:0]   exact_c_ff, c0_ff;
   logic [16:0]          den_ff;
   logic signed [34:0]   prod_ff;
   logic                 neg_ff;
   logic [35:0]          rem_ff;
   logic [35:0]          quo_ff;
   logic [5:0]           step_ff;
   result_type           res_ff;
   logic                 res_v_ff;

   logic signed [15:0] rd_a, rd_c;
   logic signed [16:0] dq;
   logic signed [17:0] dc;
   logic [35:0] mag2, dd, trial;
   logic signed [37:0] sum;

   assign rd_a = rd_data_ff[31:16];
   assign rd_c = rd_data_ff[15:0];
   assign q_take = (state_ff == IDLE) && q_valid && !res_v_ff;
   assign rsp_valid = res_v_ff;
   assign rsp_word = res_ff;

   assign wr_en = q_take && (q_word.op == OpWrite) && q_word.wr_ok;
   assign wr_index = IndexBits'(q_word.index);
   assign wr_data = {q_word.angle, q_word.coefficient};

   always_comb begin
      case (state_ff)
         RD_FIRST: rd_addr = IndexBits'(n_ff - CntBits'(1));
         SCAN:     rd_addr = IndexBits'(i_ff);
         WAIT_RD:  rd_addr = hi_ff;
         MUL:      rd_addr = hi_ff;
         default:  rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_index] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // The divisor is doubled; quotient = (2|num| + den) / (2 den).
   assign dd = {18'd0, den_ff, 1'b0};
   assign trial = {rem_ff[34:0], quo_ff[35]};
   assign mag2 = neg_ff ? 36'(-{prod_ff[34], prod_ff}) : 36'({prod_ff[34], prod_ff});
   assign sum = 38'(c0_ff) + (neg_ff ? -38'(quo_ff) : 38'(quo_ff));
   assign dq = 17'(q_ff - rd_a);
   assign dc = 18'(c1_ff - rd_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         res_v_ff <= 1'b0;
      end else begin
         if (rsp_take && res_v_ff) res_v_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               // A breakpoint write is done by the memory block and needs no state.
               if (q_take && q_word.op == OpQuery) begin
                  q_ff <= q_word.angle;
                  n_ff <= CntBits'(q_word.count);
                  found_ff <= 1'b0;
                  exact_ff <= 1'b0;
                  if (q_word.count == 7'd0) begin
                     res_ff <= '{value: '0, status: StatusEmpty, saturated: 1'b0};
                     state_ff <= DONE;
                  end else begin
                     state_ff <= RD_FIRST;
                  end
               end
            end
            RD_FIRST: begin
               // Entry 0 is on the read data here.
               first_ff <= rd_a;
               state_ff <= RD_LAST;
            end
            RD_LAST: begin
               inrange_ff <= (q_ff >= first_ff) && (q_ff <= rd_a);
               i_ff <= '0;
               state_ff <= SCAN;
            end
            SCAN: begin
               // Once i is nonzero, the read data holds entry i-1.
               if (i_ff != '0) begin
                  if (!exact_ff && rd_a == q_ff) begin
                     exact_ff <= 1'b1;
                     exact_c_ff <= rd_c;
                  end
                  if (!found_ff && i_ff > CntBits'(1) && rd_a > q_ff) begin
                     found_ff <= 1'b1;
                     hi_ff <= IndexBits'(i_ff - CntBits'(1));
                     a1_ff <= rd_a;
                     c1_ff <= rd_c;
                  end
               end
               if (i_ff == n_ff - CntBits'(1)) state_ff <= WAIT_RD;
               else i_ff <= i_ff + CntBits'(1);
            end
            WAIT_RD: begin
               // Fold the final entry of the scan, then read hi-1.
               if (exact_ff || (rd_a == q_ff && !exact_ff)) begin
                  res_ff <= '{value: exact_ff ? exact_c_ff : rd_c, status: StatusExact,
                     saturated: 1'b0};
                  state_ff <= DONE;
               end else if (!inrange_ff || (!found_ff && !(n_ff > CntBits'(1)
                     && rd_a > q_ff))) begin
                  res_ff <= '{value: '0, status: StatusRange, saturated: 1'b0};
                  state_ff <= DONE;
               end else begin
                  if (!found_ff) begin
                     hi_ff <= IndexBits'(n_ff - CntBits'(1));
                     a1_ff <= rd_a;
                     c1_ff <= rd_c;
                  end
                  state_ff <= GET_LO;
               end
            end
            GET_LO: begin
               hi_ff <= hi_ff - IndexBits'(1);
               state_ff <= MUL;
               step_ff <= 6'd0;
            end
            MUL: begin
               // Address hi-1 is applied, then its data arrives and the product is formed, then the sign is latched.
               if (step_ff == 6'd0) begin
                  step_ff <= 6'd1;
               end else if (step_ff == 6'd1) begin
                  c0_ff <= rd_c;
                  den_ff <= 17'(a1_ff - rd_a);
                  prod_ff <= 35'(dq * dc);
                  step_ff <= 6'd2;
               end else begin
                  neg_ff <= prod_ff[34];
                  rem_ff <= '0;
                  step_ff <= 6'd0;
                  state_ff <= DIV;
               end
            end
            DIV: begin
               if (step_ff == 6'd0) begin
                  quo_ff <= {mag2[34:0], 1'b0} + {19'd0, den_ff};
                  step_ff <= 6'd1;
               end else begin
                  if (trial >= dd) begin
                     rem_ff <= trial - dd;
                     quo_ff <= {quo_ff[34:0], 1'b1};
                  end else begin
                     rem_ff <= trial;
                     quo_ff <= {quo_ff[34:0], 1'b0};
                  end
                  if (step_ff == 6'd36) state_ff <= ROUND;
                  else step_ff <= step_ff + 6'd1;
               end
            end
            ROUND: begin
               if (sum > 38'sd32767)
                  res_ff <= '{value: 16'sh7FFF, status: StatusInterp, saturated: 1'b1};
               else if (sum < -38'sd32768)
                  res_ff <= '{value: 16'sh8000, status: StatusInterp, saturated: 1'b1};
               else
                  res_ff <= '{value: sum[15:0], status: StatusInterp, saturated: 1'b0};
               state_ff <= DONE;
            end
            DONE: begin
               res_v_ff <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[sv/table_linear_interpolator.sv]
// Top level of the piecewise linear interpolation table.
//  channel | ports                         | handshake
//  input   | req_push/req_full + fields    | push && !full
//  result  | rsp_empty/rsp_pop + fields    | pop && !empty
//  config  | csr_write_en, csr_write_data  | write_en
// Words wait in a two-word queue and the back end takes them one at a time, in order.
// A breakpoint write does not take the back end out of its idle state. An interpolation
// over n breakpoints reads them one by one through the single memory read port, then
// runs a 36-step shift subtract divider and rounds; an exact hit or an out-of-range
// query ends after the scan, and an empty table gives its result without a scan.
// A waiting result stalls the back end; the input stalls once two words are queued.
// Reset is synchronous and clears control state; the table is undefined.
`default_nettype none
module table_linear_interpolator import tli_pkg::*; #(
   parameter int unsigned TableDepth = TableDepthDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic               req_operation,
   input  wire logic [4:0]         req_point_index,
   input  wire logic signed [15:0] req_angle,
   input  wire logic signed [15:0] req_coefficient,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic signed [15:0]      rsp_value,
   output logic [1:0]              rsp_status,
   output logic                    rsp_saturated,
   input  wire logic               csr_write_en,
   input  wire logic [5:0]         csr_write_data
);
   localparam int unsigned IndexBits = $clog2(TableDepth);
   logic [5:0] points_used_ff;
   logic q_valid, q_take, rsp_valid;
   query_type q_word;
   result_type rsp_word;

   always_ff @(posedge clock) begin
      if (reset) points_used_ff <= 6'd0;
      else if (csr_write_en) points_used_ff <= csr_write_data;
   end

   tli_front #(.TableDepth(TableDepth)) u_front (
      .clock, .reset, .push(req_push), .full(req_full),
      .operation(req_operation), .point_index(req_point_index),
      .angle(req_angle), .coefficient(req_coefficient),
      .points_used(points_used_ff), .q_valid, .q_word, .q_take);

   tli_back #(.TableDepth(TableDepth), .IndexBits(IndexBits)) u_back (
      .clock, .reset, .q_valid, .q_word,
      .q_take, .rsp_valid, .rsp_word, .rsp_take(rsp_pop));

   assign rsp_empty = !rsp_valid;
   assign rsp_value = rsp_word.value;
   assign rsp_status = rsp_word.status;
   assign rsp_saturated = rsp_word.saturated;
endmodule
`default_nettype wire

[sv/tli_checker.sv]
// Port-level checker for the interpolation table, bound to the top level.
`default_nettype none
`include "table_linear_interpolator_assert.svh"
module tli_checker import tli_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [15:0] rsp_value,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_saturated
);
   `TLI_ASSERT_IMPL(a_sat_interp, clock, reset, !rsp_empty && rsp_saturated, rsp_status == StatusInterp)
   `TLI_ASSERT_IMPL(a_zero_range, clock, reset, !rsp_empty && (rsp_status == StatusRange || rsp_status == StatusEmpty), rsp_value == 16'd0)
   `TLI_ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_value))
endmodule

bind table_linear_interpolator tli_checker u_tli_checker (
   .clock, .reset, .rsp_empty, .rsp_pop, .rsp_value, .rsp_status, .rsp_saturated);
`default_nettype wire
